FILE: sv/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the sieve prime counter.
// ----------------------------------------------------------------------------
package scp_pkg;

	localparam int unsigned LIMIT_W = 17;
	localparam int unsigned ADDR_W  = 16;
	localparam int unsigned P_W     = 9;
	localparam int unsigned SQ_W    = 2 * P_W;
	localparam int unsigned STEP_W  = P_W + 1;

	localparam logic [LIMIT_W-1:0] MAX_N     = 17'd65536;
	localparam logic [LIMIT_W-1:0] MIN_N     = 17'd2;
	localparam logic [P_W-1:0]     FIRST_ODD = 9'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PCHK,
		ST_PWAIT,
		ST_MARK,
		ST_COUNT,
		ST_CDRAIN,
		ST_FINISH
	} scp_state_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic              wdata;
	} scp_map_req_t;

	typedef struct packed {
		logic               valid;
		logic [LIMIT_W-1:0] count;
		logic               err;
	} scp_result_t;

endpackage

FILE: sv/scp_map.sv
// ----------------------------------------------------------------------------
// scp_map
// Single-port one-bit scratch map with a registered read.
// ----------------------------------------------------------------------------
module scp_map (
	input  logic                 clk,
	input  scp_pkg::scp_map_req_t req,
	output logic                 rdata
);

	logic mem [scp_pkg::MAX_N];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end else begin
				rdata_q <= mem[req.addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: sv/scp_seq.sv
// ----------------------------------------------------------------------------
// scp_seq
// Sequencer for the sieve: clear and even marking, odd prime marking and the
// final count, with the index and p steps driven through one shared adder and one comparator.
// ----------------------------------------------------------------------------
module scp_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [scp_pkg::LIMIT_W-1:0]    limit,
	output logic                           idle,
	output scp_pkg::scp_result_t           res,
	input  logic                           res_take,
	output scp_pkg::scp_map_req_t          map_req,
	input  logic                           map_rdata
);

	scp_pkg::scp_state_t state_q, state_d;

	logic [scp_pkg::LIMIT_W-1:0] n_q;
	logic [scp_pkg::LIMIT_W-1:0] idx_q;
	logic [scp_pkg::STEP_W-1:0]  step_q;
	logic [scp_pkg::P_W-1:0]     p_q;
	logic [scp_pkg::LIMIT_W-1:0] cnt_q;
	logic                        err_q;
	logic                        rd_vld_s1;

	logic [scp_pkg::SQ_W-1:0]    sq;
	logic [scp_pkg::SQ_W-1:0]    cmp_a;
	logic                        lt;
	logic [scp_pkg::LIMIT_W-1:0] add_a, add_b, add_sum;
	logic                        bad_limit;
	logic                        init_bit;

	assign sq = scp_pkg::SQ_W'(p_q) * scp_pkg::SQ_W'(p_q);

	// One comparator against the limit: the square of p while checking the
	// outer loop, otherwise the running index.
	assign cmp_a = (state_q == scp_pkg::ST_PCHK) ? sq : scp_pkg::SQ_W'(idx_q);
	assign lt    = cmp_a < scp_pkg::SQ_W'(n_q);

	// One adder: the index advances by one or by 2p, and p advances by two
	// when the index is not moving.
	always_comb begin
		add_a = idx_q;
		add_b = scp_pkg::LIMIT_W'(1);
		case (state_q)
			scp_pkg::ST_MARK: begin
				if (lt) begin
					add_b = scp_pkg::LIMIT_W'(step_q);
				end else begin
					add_a = scp_pkg::LIMIT_W'(p_q);
					add_b = scp_pkg::LIMIT_W'(2);
				end
			end
			scp_pkg::ST_PWAIT: begin
				add_a = scp_pkg::LIMIT_W'(p_q);
				add_b = scp_pkg::LIMIT_W'(2);
			end
			default: begin
				add_a = idx_q;
				add_b = scp_pkg::LIMIT_W'(1);
			end
		endcase
	end

	assign add_sum   = add_a + add_b;
	assign bad_limit = (limit < scp_pkg::MIN_N) || (limit > scp_pkg::MAX_N);
	// Clearing and even marking share one pass: 0, 1 and even numbers from
	// four are composite, everything else starts as prime.
	assign init_bit  = (idx_q < scp_pkg::LIMIT_W'(2))
		|| ((idx_q >= scp_pkg::LIMIT_W'(4)) && !idx_q[0]);

	always_comb begin
		state_d = state_q;
		case (state_q)
			scp_pkg::ST_IDLE: begin
				if (start) begin
					state_d = bad_limit ? scp_pkg::ST_FINISH : scp_pkg::ST_CLEAR;
				end
			end
			scp_pkg::ST_CLEAR:  if (!lt) state_d = scp_pkg::ST_PCHK;
			scp_pkg::ST_PCHK:   state_d = lt ? scp_pkg::ST_PWAIT : scp_pkg::ST_COUNT;
			scp_pkg::ST_PWAIT:  state_d = map_rdata ? scp_pkg::ST_PCHK : scp_pkg::ST_MARK;
			scp_pkg::ST_MARK:   if (!lt) state_d = scp_pkg::ST_PCHK;
			scp_pkg::ST_COUNT:  if (!lt) state_d = scp_pkg::ST_CDRAIN;
			scp_pkg::ST_CDRAIN: state_d = scp_pkg::ST_FINISH;
			scp_pkg::ST_FINISH: if (res_take) state_d = scp_pkg::ST_IDLE;
			default:            state_d = scp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		idle          = 1'b0;
		res.valid     = 1'b0;
		res.count     = cnt_q;
		res.err       = err_q;
		map_req.en    = 1'b0;
		map_req.we    = 1'b0;
		map_req.addr  = idx_q[scp_pkg::ADDR_W-1:0];
		map_req.wdata = 1'b1;
		case (state_q)
			scp_pkg::ST_IDLE: idle = 1'b1;
			scp_pkg::ST_CLEAR: begin
				map_req.en    = lt;
				map_req.we    = lt;
				map_req.wdata = init_bit;
			end
			scp_pkg::ST_PCHK: begin
				map_req.en   = lt;
				map_req.addr = scp_pkg::ADDR_W'(p_q);
			end
			scp_pkg::ST_MARK: begin
				map_req.en = lt;
				map_req.we = lt;
			end
			scp_pkg::ST_COUNT:  map_req.en = lt;
			scp_pkg::ST_FINISH: res.valid = 1'b1;
			default: begin
				idle = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= scp_pkg::ST_IDLE;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == scp_pkg::ST_COUNT) && lt;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1 && !map_rdata) begin
			cnt_q <= cnt_q + scp_pkg::LIMIT_W'(1);
		end
		case (state_q)
			scp_pkg::ST_IDLE: begin
				if (start) begin
					n_q   <= limit;
					err_q <= bad_limit;
					cnt_q <= '0;
					idx_q <= '0;
					p_q   <= scp_pkg::FIRST_ODD;
				end
			end
			scp_pkg::ST_CLEAR: begin
				if (lt) begin
					idx_q <= add_sum;
				end
			end
			scp_pkg::ST_PCHK: begin
				if (!lt) begin
					idx_q <= '0;
				end
			end
			scp_pkg::ST_PWAIT: begin
				if (map_rdata) begin
					p_q <= add_sum[scp_pkg::P_W-1:0];
				end else begin
					idx_q  <= sq[scp_pkg::LIMIT_W-1:0];
					step_q <= {p_q, 1'b0};
				end
			end
			scp_pkg::ST_MARK: begin
				if (lt) begin
					idx_q <= add_sum;
				end else begin
					p_q <= add_sum[scp_pkg::P_W-1:0];
				end
			end
			scp_pkg::ST_COUNT: begin
				if (lt) begin
					idx_q <= add_sum;
				end
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_write_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(map_req.en && map_req.we) |-> (scp_pkg::LIMIT_W'(map_req.addr) < n_q))
		else $error("map write at or beyond the limit");

	a_finish_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scp_pkg::ST_FINISH && res_take) |=> (state_q == scp_pkg::ST_IDLE))
		else $error("sequencer did not return to idle after the result was taken");

	a_p_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == scp_pkg::ST_PCHK) |-> p_q[0])
		else $error("outer sieve variable is even");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.err) |-> (res.count == '0))
		else $error("error result carries a non-zero count");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.err) |-> (res.count < n_q))
		else $error("prime count not below the limit");
`endif

endmodule

FILE: sv/sieve_prime_count.sv
// ----------------------------------------------------------------------------
// sieve_prime_count
// Counts the primes below a limit with a sieve of Eratosthenes on a one-bit
// scratch map.
// ----------------------------------------------------------------------------
//  channel  signals                              width  direction
//  in       in_valid, in_ready, limit             17     into the block
//  out      out_valid, out_ready, prime_count,    17, 1  out of the block
//           limit_error
//
// A valid limit N clears the map, marks the multiples of each odd prime
// below sqrt(N), checking each odd p in turn, and then counts the map;
// its run time is set by the single port of the scratch map. A bad limit
// goes straight to the result.
// The map needs no clearing after reset, as each run writes every address below the limit before reading it.
// A result waits in the output register; the next transaction is taken
// while it waits, but a second result stalls the sequencer until the first
// is taken.
// ----------------------------------------------------------------------------
module sieve_prime_count (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [scp_pkg::LIMIT_W-1:0] limit,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [scp_pkg::LIMIT_W-1:0] prime_count,
	output logic                        limit_error
);

	scp_pkg::scp_result_t  res;
	scp_pkg::scp_map_req_t map_req;
	logic                  map_rdata;
	logic                  idle;
	logic                  res_take;
	logic                  out_valid_q;
	logic [scp_pkg::LIMIT_W-1:0] count_q;
	logic                  err_q;

	assign in_ready = idle;
	assign res_take = res.valid && (!out_valid_q || out_ready);

	scp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.limit     (limit),
		.idle      (idle),
		.res       (res),
		.res_take  (res_take),
		.map_req   (map_req),
		.map_rdata (map_rdata)
	);

	scp_map u_map (
		.clk   (clk),
		.req   (map_req),
		.rdata (map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			count_q <= res.count;
			err_q   <= res.err;
		end
	end

	assign out_valid   = out_valid_q;
	assign prime_count = count_q;
	assign limit_error = err_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> (out_valid_q && $stable(count_q) && $stable(err_q)))
		else $error("pending result changed before its transaction");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !in_ready)
		else $error("input ready while a result is being delivered");

	a_take_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_take |=> out_valid_q)
		else $error("taken result not presented");
`endif

endmodule
